// ===== rtl/mcrsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcrsd_pkg
// Shared constants and types for the rest stability detector.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrsd_pkg;

	localparam int WINDOW_DEPTH = 20;
	localparam int SAMPLE_BITS  = 12;
	localparam int FIELD_BITS   = 12;
	localparam int CHANNELS     = 6;
	localparam int LIMIT_BITS   = 13;
	localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
	localparam int FILL_BITS    = $clog2(WINDOW_DEPTH + 1);

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(50);

	localparam int CH_LEFT_X     = 0;
	localparam int CH_LEFT_Y     = 1;
	localparam int CH_RIGHT_X    = 2;
	localparam int CH_RIGHT_Y    = 3;
	localparam int CH_LEFT_HALL  = 4;
	localparam int CH_RIGHT_HALL = 5;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [CHANNELS-1:0] sample_set_t;
	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef struct packed {
		logic clear;
		logic take;
	} mm_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/mcrsd_ram.sv =====
// ----------------------------------------------------------------------------
// mcrsd_ram
// Sample window storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrsd_ram
	import mcrsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        wr_en,
	input  wire addr_t       wr_addr,
	input  wire sample_set_t wr_data,
	input  wire addr_t       rd_addr,
	output sample_set_t      rd_data
);

	sample_set_t mem_q [WINDOW_DEPTH];
	sample_set_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/mcrsd_minmax.sv =====
// ----------------------------------------------------------------------------
// mcrsd_minmax
// Per-channel running minimum and maximum over the scanned window.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrsd_minmax
	import mcrsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mm_ctrl_t    ctrl,
	input  wire sample_set_t sample,
	output sample_set_t      lo,
	output sample_set_t      hi
);

	logic        first_q;
	sample_set_t lo_q;
	sample_set_t hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (ctrl.clear) begin
			first_q <= 1'b1;
		end else if (ctrl.take) begin
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (first_q || sample[c] < lo_q[c]) begin
					lo_q[c] <= sample[c];
				end
				if (first_q || sample[c] > hi_q[c]) begin
					hi_q[c] <= sample[c];
				end
			end
		end
	end

	assign lo = lo_q;
	assign hi = hi_q;

endmodule

`default_nettype wire

// ===== rtl/multi_channel_rest_stability_detector_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_rest_stability_detector_unit
// Sliding-window min/max rest detector for six sensor channels.
//
// Input channel (in_valid / in_stall): one set of six samples plus restart,
// transferred when in_valid is high and in_stall low. Each transfer yields
// exactly one result on the output channel (out_valid / out_stall).
// The set is written to the window memory on the transfer edge. Until the
// window holds WINDOW_DEPTH sets the item passes from idle straight to
// evaluation. Once full, the memory's single read port is swept over all
// WINDOW_DEPTH entries, one per cycle, in scan, then drain and evaluation.
// in_stall is high while an item is at work; the block takes a new item
// while the previous result still waits in the output register.
// A result that finds the output register occupied and stalled holds until
// it is taken. Reset empties the window (fill count and write slot to zero)
// and sets spread_limit to 50. The config channel (cfg_valid / cfg_ready)
// writes spread_limit; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_rest_stability_detector_unit
	import mcrsd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  restart,
	input  wire logic [FIELD_BITS-1:0] left_x,
	input  wire logic [FIELD_BITS-1:0] left_y,
	input  wire logic [FIELD_BITS-1:0] right_x,
	input  wire logic [FIELD_BITS-1:0] right_y,
	input  wire logic [FIELD_BITS-1:0] left_hall,
	input  wire logic [FIELD_BITS-1:0] right_hall,

	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       window_full,
	output logic                       stable,
	output logic [FIELD_BITS-1:0]      left_x_mid,
	output logic [FIELD_BITS-1:0]      left_y_mid,
	output logic [FIELD_BITS-1:0]      right_x_mid,
	output logic [FIELD_BITS-1:0]      right_y_mid,
	output logic [FIELD_BITS-1:0]      left_hall_mid,
	output logic [FIELD_BITS-1:0]      right_hall_mid,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [LIMIT_BITS-1:0] spread_limit
);

	state_t                state_q, state_d;
	logic                  accept;
	logic                  issue_rd;
	logic                  load_out;
	logic                  out_free;

	logic [LIMIT_BITS-1:0] limit_q;
	addr_t                 slot_q;
	logic [FILL_BITS-1:0]  fill_q;
	logic                  full_q;
	addr_t                 rd_addr_q;
	logic                  rd_vld_s1;

	addr_t                 slot_cur;
	logic [FILL_BITS-1:0]  fill_cur;
	logic [FILL_BITS-1:0]  fill_nxt;
	sample_set_t           wr_set;
	sample_set_t           rd_set;
	sample_set_t           lo;
	sample_set_t           hi;
	mm_ctrl_t              mm_ctrl;

	logic                  stable_c;
	sample_set_t           mid_c;

	logic                  out_valid_q;
	logic                  full_out_q;
	logic                  stable_out_q;
	sample_set_t           mid_out_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		issue_rd = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					state_d = (fill_nxt == FILL_BITS'(WINDOW_DEPTH)) ? ST_SCAN : ST_EVAL;
				end
			end
			ST_SCAN: begin
				issue_rd = 1'b1;
				if (rd_addr_q == addr_t'(WINDOW_DEPTH - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// window bookkeeping
	assign slot_cur = restart ? '0 : slot_q;
	assign fill_cur = restart ? '0 : fill_q;
	assign fill_nxt = (fill_cur == FILL_BITS'(WINDOW_DEPTH)) ? fill_cur
		: fill_cur + FILL_BITS'(1);

	always_comb begin
		wr_set                = '0;
		wr_set[CH_LEFT_X]     = SAMPLE_BITS'(left_x);
		wr_set[CH_LEFT_Y]     = SAMPLE_BITS'(left_y);
		wr_set[CH_RIGHT_X]    = SAMPLE_BITS'(right_x);
		wr_set[CH_RIGHT_Y]    = SAMPLE_BITS'(right_y);
		wr_set[CH_LEFT_HALL]  = SAMPLE_BITS'(left_hall);
		wr_set[CH_RIGHT_HALL] = SAMPLE_BITS'(right_hall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= LIMIT_RESET;
			slot_q    <= '0;
			fill_q    <= '0;
			full_q    <= 1'b0;
			rd_addr_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= spread_limit;
			end
			if (accept) begin
				slot_q    <= (slot_cur == addr_t'(WINDOW_DEPTH - 1)) ? '0
					: slot_cur + addr_t'(1);
				fill_q    <= fill_nxt;
				full_q    <= (fill_nxt == FILL_BITS'(WINDOW_DEPTH));
				rd_addr_q <= '0;
			end else if (issue_rd) begin
				rd_addr_q <= rd_addr_q + addr_t'(1);
			end
			rd_vld_s1 <= issue_rd;
		end
	end

	mcrsd_ram u_ram (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (slot_cur),
		.wr_data (wr_set),
		.rd_addr (rd_addr_q),
		.rd_data (rd_set)
	);

	assign mm_ctrl.clear = accept;
	assign mm_ctrl.take  = rd_vld_s1;

	mcrsd_minmax u_minmax (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mm_ctrl),
		.sample (rd_set),
		.lo     (lo),
		.hi     (hi)
	);

	// spread check and midpoints
	always_comb begin
		logic [SAMPLE_BITS-1:0] spread;
		logic [SAMPLE_BITS:0]   sum;
		stable_c = full_q;
		mid_c    = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			spread = hi[c] - lo[c];
			sum    = {1'b0, hi[c]} + {1'b0, lo[c]};
			if (!(LIMIT_BITS'(spread) < limit_q)) begin
				stable_c = 1'b0;
			end
			mid_c[c] = sum[SAMPLE_BITS:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			full_out_q   <= full_q;
			stable_out_q <= stable_c;
			mid_out_q    <= stable_c ? mid_c : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign window_full    = full_out_q;
	assign stable         = stable_out_q;
	assign left_x_mid     = FIELD_BITS'(mid_out_q[CH_LEFT_X]);
	assign left_y_mid     = FIELD_BITS'(mid_out_q[CH_LEFT_Y]);
	assign right_x_mid    = FIELD_BITS'(mid_out_q[CH_RIGHT_X]);
	assign right_y_mid    = FIELD_BITS'(mid_out_q[CH_RIGHT_Y]);
	assign left_hall_mid  = FIELD_BITS'(mid_out_q[CH_LEFT_HALL]);
	assign right_hall_mid = FIELD_BITS'(mid_out_q[CH_RIGHT_HALL]);

endmodule

`default_nettype wire

// ===== tb/multi_channel_rest_stability_detector_unit_tb.sv =====
// ----------------------------------------------------------------------------
// multi_channel_rest_stability_detector_unit_tb
// Self-checking bench for the six-channel rest stability detector. Sample
// sets are sent as settled runs of random width around the spread limit,
// mixed with full-range noise and restarts. Each transfer is predicted
// against a sliding-window min/max scoreboard. Sender gaps and receiver
// stalls are random, and the limit is rewritten between drained phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_channel_rest_stability_detector_unit_tb;
	import mcrsd_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 1050;
	localparam int SETTLE_CYCLES  = 40;
	localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;

	typedef struct packed {
		logic        full;
		logic        stable;
		sample_set_t mids;
	} rest_result_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_RUNS
	} stall_mode_t;

	class rest_scoreboard;
		sample_set_t  window_sets [WINDOW_DEPTH];
		int unsigned  write_slot;
		int unsigned  fill_count;
		int unsigned  limit;
		rest_result_t expected_q [$];
		int unsigned  mismatches;
		int unsigned  results_seen;

		function new();
			write_slot   = 0;
			fill_count   = 0;
			limit        = LIMIT_RESET;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_limit(logic [LIMIT_BITS-1:0] value);
			limit = value;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function string mid_name(int c);
			case (c)
				CH_LEFT_X:    return "left_x_mid";
				CH_LEFT_Y:    return "left_y_mid";
				CH_RIGHT_X:   return "right_x_mid";
				CH_RIGHT_Y:   return "right_y_mid";
				CH_LEFT_HALL: return "left_hall_mid";
				default:      return "right_hall_mid";
			endcase
		endfunction

		function void note_input(logic rst, sample_set_t set);
			rest_result_t r;
			int unsigned  lo;
			int unsigned  hi;
			if (rst) begin
				fill_count = 0;
				write_slot = 0;
			end
			window_sets[write_slot] = set;
			write_slot = (write_slot + 1) % WINDOW_DEPTH;
			if (fill_count < WINDOW_DEPTH)
				fill_count++;
			r = '0;
			r.full = (fill_count == WINDOW_DEPTH);
			if (r.full) begin
				r.stable = 1'b1;
				for (int c = 0; c < CHANNELS; c++) begin
					lo = SAMPLE_MAX;
					hi = 0;
					for (int k = 0; k < WINDOW_DEPTH; k++) begin
						if (window_sets[k][c] < lo)
							lo = window_sets[k][c];
						if (window_sets[k][c] > hi)
							hi = window_sets[k][c];
					end
					if (hi - lo >= limit)
						r.stable = 1'b0;
					r.mids[c] = sample_t'((lo + hi) >> 1);
				end
				if (!r.stable)
					r.mids = '0;
			end
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			if (mismatches < 100)
				$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_result(rest_result_t got);
			rest_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d with no transfer waiting", results_seen));
			end else begin
				want = expected_q.pop_front();
				if (got.full !== want.full)
					report($sformatf("result %0d window_full got %b expected %b",
						results_seen, got.full, want.full));
				if (got.stable !== want.stable)
					report($sformatf("result %0d stable got %b expected %b",
						results_seen, got.stable, want.stable));
				for (int c = 0; c < CHANNELS; c++) begin
					if (got.mids[c] !== want.mids[c])
						report($sformatf("result %0d %s got %0d expected %0d", results_seen,
							mid_name(c), got.mids[c], want.mids[c]));
				end
			end
			results_seen++;
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  restart = 1'b0;
	logic [FIELD_BITS-1:0] left_x = '0;
	logic [FIELD_BITS-1:0] left_y = '0;
	logic [FIELD_BITS-1:0] right_x = '0;
	logic [FIELD_BITS-1:0] right_y = '0;
	logic [FIELD_BITS-1:0] left_hall = '0;
	logic [FIELD_BITS-1:0] right_hall = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  window_full;
	logic                  stable;
	logic [FIELD_BITS-1:0] left_x_mid;
	logic [FIELD_BITS-1:0] left_y_mid;
	logic [FIELD_BITS-1:0] right_x_mid;
	logic [FIELD_BITS-1:0] right_y_mid;
	logic [FIELD_BITS-1:0] left_hall_mid;
	logic [FIELD_BITS-1:0] right_hall_mid;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [LIMIT_BITS-1:0] spread_limit = LIMIT_RESET;

	rest_scoreboard sb;
	int unsigned    quiet_cycles = 0;
	int unsigned    burst_left = 0;
	bit             gaps_on = 1'b1;
	int unsigned    random_items = 0;
	stall_mode_t    stall_mode = STALL_NONE;
	int unsigned    mode_left = 0;
	int unsigned    run_left = 0;
	int unsigned    stall_tick = 0;

	multi_channel_rest_stability_detector_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.restart        (restart),
		.left_x         (left_x),
		.left_y         (left_y),
		.right_x        (right_x),
		.right_y        (right_y),
		.left_hall      (left_hall),
		.right_hall     (right_hall),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.window_full    (window_full),
		.stable         (stable),
		.left_x_mid     (left_x_mid),
		.left_y_mid     (left_y_mid),
		.right_x_mid    (right_x_mid),
		.right_y_mid    (right_y_mid),
		.left_hall_mid  (left_hall_mid),
		.right_hall_mid (right_hall_mid),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.spread_limit   (spread_limit)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic sample_set_t input_set();
		sample_set_t s;
		s[CH_LEFT_X]     = left_x;
		s[CH_LEFT_Y]     = left_y;
		s[CH_RIGHT_X]    = right_x;
		s[CH_RIGHT_Y]    = right_y;
		s[CH_LEFT_HALL]  = left_hall;
		s[CH_RIGHT_HALL] = right_hall;
		return s;
	endfunction

	function automatic rest_result_t output_result();
		rest_result_t r;
		r.full                = window_full;
		r.stable              = stable;
		r.mids[CH_LEFT_X]     = left_x_mid;
		r.mids[CH_LEFT_Y]     = left_y_mid;
		r.mids[CH_RIGHT_X]    = right_x_mid;
		r.mids[CH_RIGHT_Y]    = right_y_mid;
		r.mids[CH_LEFT_HALL]  = left_hall_mid;
		r.mids[CH_RIGHT_HALL] = right_hall_mid;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_limit(spread_limit);
			if (in_valid && !in_stall)
				sb.note_input(restart, input_set());
			if (out_valid && !out_stall)
				sb.check_result(output_result());
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (mode_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left  <= $urandom_range(50, 400);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
			STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
			default: begin
				if (run_left == 0) begin
					out_stall <= ~out_stall;
					run_left  <= $urandom_range(1, 25);
				end else begin
					run_left <= run_left - 1;
				end
			end
		endcase
	end

	task automatic send_item(logic rst, sample_set_t s);
		in_valid   <= 1'b1;
		restart    <= rst;
		left_x     <= s[CH_LEFT_X];
		left_y     <= s[CH_LEFT_Y];
		right_x    <= s[CH_RIGHT_X];
		right_y    <= s[CH_RIGHT_Y];
		left_hall  <= s[CH_LEFT_HALL];
		right_hall <= s[CH_RIGHT_HALL];
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause_cycles(int unsigned n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic paced_send(logic rst, sample_set_t s);
		if (burst_left == 0) begin
			if ($urandom_range(0, 5) == 0)
				gaps_on = !gaps_on;
			if (gaps_on)
				pause_cycles($urandom_range(1, 40));
			burst_left = $urandom_range(1, 30);
		end
		send_item(rst, s);
		burst_left--;
		random_items++;
	endtask

	task automatic drain();
		@(posedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_limit(int unsigned value);
		cfg_valid    <= 1'b1;
		spread_limit <= LIMIT_BITS'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic settled_sequence(int unsigned lim);
		int unsigned len;
		int unsigned amp;
		int unsigned pick;
		int unsigned amp_c [CHANNELS];
		int unsigned base_c [CHANNELS];
		sample_set_t s;
		logic        rst;
		len = $urandom_range(20, 40);
		case ($urandom_range(0, 3))
			0:       amp = (lim > 0) ? lim - 1 : 0;
			1:       amp = lim;
			2:       amp = $urandom_range(0, lim);
			default: amp = 0;
		endcase
		if (amp > SAMPLE_MAX)
			amp = SAMPLE_MAX;
		for (int c = 0; c < CHANNELS; c++)
			amp_c[c] = amp;
		if ($urandom_range(0, 5) == 0) begin
			pick = $urandom_range(0, CHANNELS - 1);
			if (amp_c[pick] < SAMPLE_MAX)
				amp_c[pick]++;
		end
		for (int c = 0; c < CHANNELS; c++)
			base_c[c] = $urandom_range(0, SAMPLE_MAX - amp_c[c]);
		for (int n = 0; n < len; n++) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (n == 0)
					s[c] = sample_t'(base_c[c]);
				else if (n == 1)
					s[c] = sample_t'(base_c[c] + amp_c[c]);
				else
					s[c] = sample_t'(base_c[c] + $urandom_range(0, amp_c[c]));
			end
			if ($urandom_range(0, 29) == 0)
				s[$urandom_range(0, CHANNELS - 1)] = sample_t'($urandom_range(0, SAMPLE_MAX));
			rst = (n == 0) && ($urandom_range(0, 3) != 0);
			paced_send(rst, s);
		end
	endtask

	task automatic noise_burst();
		sample_set_t s;
		repeat ($urandom_range(1, 12)) begin
			for (int c = 0; c < CHANNELS; c++)
				s[c] = sample_t'($urandom_range(0, SAMPLE_MAX));
			paced_send($urandom_range(0, 5) == 0, s);
		end
	endtask

	initial begin
		sample_set_t s;
		int unsigned limit_plan [$];
		int unsigned phase;
		int unsigned lim;
		sb = new();
		limit_plan = '{0, 1, 4096, 8191, 2, 4095, 50};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_limit(LIMIT_RESET);

		s[CH_LEFT_X]     = sample_t'(SAMPLE_MAX);
		s[CH_LEFT_Y]     = '0;
		s[CH_RIGHT_X]    = sample_t'(SAMPLE_MAX);
		s[CH_RIGHT_Y]    = '0;
		s[CH_LEFT_HALL]  = sample_t'(2048);
		s[CH_RIGHT_HALL] = sample_t'(2047);
		for (int n = 0; n < WINDOW_DEPTH; n++)
			send_item(n == 0, s);
		s[CH_LEFT_X] = sample_t'(SAMPLE_MAX - 49);
		send_item(1'b0, s);
		s[CH_LEFT_Y] = sample_t'(50);
		send_item(1'b0, s);
		send_item(1'b1, s);

		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			drain();
			if (phase < limit_plan.size())
				lim = limit_plan[phase];
			else if ($urandom_range(0, 1) == 0)
				lim = $urandom_range(1, 160);
			else
				lim = $urandom_range(1, 8191);
			write_limit(lim);
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 9) < 7)
					settled_sequence(lim);
				else
					noise_burst();
				if ($urandom_range(0, 7) == 0)
					drain();
			end
			phase++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mcrsd_pkg.sv
rtl/mcrsd_ram.sv
rtl/mcrsd_minmax.sv
rtl/multi_channel_rest_stability_detector_unit.sv
tb/multi_channel_rest_stability_detector_unit_tb.sv
